[design/fpa_pkg.sv]
`timescale 1ns / 1ps
// shared action codes, widths, result types and saturation helpers
// for the q24.8 alu; no dependencies

package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 4;

  localparam logic [ACT_W-1:0] ACT_ADD = 4'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 4'd3;
  localparam logic [ACT_W-1:0] ACT_MIN = 4'd4;
  localparam logic [ACT_W-1:0] ACT_MAX = 4'd5;
  localparam logic [ACT_W-1:0] ACT_INC = 4'd6;
  localparam logic [ACT_W-1:0] ACT_DEC = 4'd7;
  localparam logic [ACT_W-1:0] ACT_INT = 4'd8;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              ovf;
  } sat_t;

  // per-transaction status carried alongside the datapath
  typedef struct packed {
    logic              is_div;
    logic              neg;
    logic              dbz;
    logic              lt;
    logic              eq;
    logic              gt;
    logic [DATA_W-1:0] value;
    logic              ovf;
  } res_t;

  // clamp a 33-bit signed sum to 32 bits
  function automatic sat_t sat_sum(input logic [DATA_W:0] s);
    sat_t r;
    r.ovf   = s[DATA_W] ^ s[DATA_W-1];
    r.value = r.ovf ? (s[DATA_W] ? NEG_MAX : POS_MAX) : s[DATA_W-1:0];
    return r;
  endfunction

  // apply sign to a magnitude and clamp
  function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
    sat_t r;
    if (neg) begin
      r.ovf   = mag > 65'h0_8000_0000;
      r.value = r.ovf ? NEG_MAX : ((~mag[DATA_W-1:0]) + 32'd1);
    end else begin
      r.ovf   = mag > 65'h0_7FFF_FFFF;
      r.value = r.ovf ? POS_MAX : mag[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/fpa_div.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage
// uses fpa_pkg for the data width

module fpa_div #(
  parameter int NW = 40
) (
  input  logic                          clk,
  input  logic [NW-1:0]                 in_num,
  input  logic [fpa_pkg::DATA_W-1:0]    in_den,
  output logic [NW-1:0]                 out_quo,
  output logic [fpa_pkg::DATA_W-1:0]    out_rem,
  output logic [fpa_pkg::DATA_W-1:0]    out_den
);

  localparam int DW = fpa_pkg::DATA_W;

  logic [DW-1:0] rem_r   [NW];
  logic [NW-1:0] nq_r    [NW];
  logic [DW-1:0] den_r   [NW];
  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] nq_nxt  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] src_rem;
    logic [NW-1:0] src_nq;
    logic [DW-1:0] src_den;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign src_rem = '0;
      assign src_nq  = in_num;
      assign src_den = in_den;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_nq  = nq_r[k-1];
      assign src_den = den_r[k-1];
    end

    // numerator bits shift out the top, quotient bits fill from the bottom
    always_comb begin
      trial      = {src_rem, src_nq[NW-1]};
      ge         = trial >= {1'b0, src_den};
      rem_nxt[k] = ge ? DW'(trial - {1'b0, src_den}) : trial[DW-1:0];
      nq_nxt[k]  = {src_nq[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt[k];
      nq_r[k]  <= nq_nxt[k];
      den_r[k] <= src_den;
    end
  end

  assign out_quo = nq_r[NW-1];
  assign out_rem = rem_r[NW-1];
  assign out_den = den_r[NW-1];

endmodule

[design/fixed_point_q24_8_alu_unit.sv]
`timescale 1ns / 1ps
// top level of the signed q24.8 fixed-point alu
// uses fpa_pkg and the pipelined divider fpa_div
//
// channel   ports                                   handshake
// input     in_action, in_operand_a, in_operand_b   start, busy (always low)
// result    out_result_value, out_a_* , flags       out_valid strobe, no stall
//
// one transaction accepted every cycle; results appear in order. the depth
// is set by the divider, one quotient bit per stage; other actions wait in
// a matching delay line. synchronous active-low reset clears all valid bits.
// the receiver cannot stall, so the pipeline never holds.

module fixed_point_q24_8_alu_unit #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fpa_pkg::ACT_W-1:0]   in_action,
  input  logic signed [31:0]          in_operand_a,
  input  logic signed [31:0]          in_operand_b,
  output logic                        out_valid,
  output logic signed [31:0]          out_result_value,
  output logic                        out_a_less,
  output logic                        out_a_equal,
  output logic                        out_a_greater,
  output logic                        out_divide_by_zero,
  output logic                        out_overflow
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int NW = DW + FRACTION_BITS;
  localparam int DLY = NW - 1;

  assign busy = 1'b0;

  // stage 1: input capture
  logic                      s1_vld_r;
  logic [fpa_pkg::ACT_W-1:0] s1_act_r;
  logic signed [DW-1:0]      s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_act_r <= in_action;
    s1_a_r   <= in_operand_a;
    s1_b_r   <= in_operand_b;
  end

  // stage 2: magnitudes and compares
  logic                      s2_vld_r;
  logic [fpa_pkg::ACT_W-1:0] s2_act_r;
  logic signed [DW-1:0]      s2_a_r, s2_b_r;
  logic [DW-1:0]             s2_ma_r, s2_mb_r;
  logic                      s2_neg_r, s2_lt_r, s2_eq_r, s2_gt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_act_r <= s1_act_r;
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
    s2_ma_r  <= s1_a_r[DW-1] ? DW'(-s1_a_r) : s1_a_r;
    s2_mb_r  <= s1_b_r[DW-1] ? DW'(-s1_b_r) : s1_b_r;
    s2_neg_r <= s1_a_r[DW-1] ^ s1_b_r[DW-1];
    s2_lt_r  <= s1_a_r < s1_b_r;
    s2_eq_r  <= s1_a_r == s1_b_r;
    s2_gt_r  <= s1_a_r > s1_b_r;
  end

  // stage 3: product and the simple actions
  fpa_pkg::sat_t   fast_nxt;
  logic [DW:0]     a_ext, b_ext;

  always_comb begin
    a_ext    = {s2_a_r[DW-1], s2_a_r};
    b_ext    = {s2_b_r[DW-1], s2_b_r};
    fast_nxt = '0;
    case (s2_act_r)
      fpa_pkg::ACT_ADD: fast_nxt = fpa_pkg::sat_sum(a_ext + b_ext);
      fpa_pkg::ACT_SUB: fast_nxt = fpa_pkg::sat_sum(a_ext - b_ext);
      fpa_pkg::ACT_INC: fast_nxt = fpa_pkg::sat_sum(a_ext + 33'd1);
      fpa_pkg::ACT_DEC: fast_nxt = fpa_pkg::sat_sum(a_ext - 33'd1);
      fpa_pkg::ACT_MIN: fast_nxt.value = s2_lt_r ? s2_a_r : s2_b_r;
      fpa_pkg::ACT_MAX: fast_nxt.value = s2_gt_r ? s2_a_r : s2_b_r;
      fpa_pkg::ACT_INT: fast_nxt.value = DW'(s2_a_r >>> FRACTION_BITS);
      default:          fast_nxt = '0;
    endcase
  end

  logic                      s3_vld_r;
  fpa_pkg::res_t             s3_r;
  logic                      s3_mul_r;
  logic [2*DW-1:0]           s3_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_r.is_div <= s2_act_r == fpa_pkg::ACT_DIV;
    s3_r.neg    <= s2_neg_r;
    s3_r.dbz    <= (s2_act_r == fpa_pkg::ACT_DIV) && (s2_mb_r == '0);
    s3_r.lt     <= s2_lt_r;
    s3_r.eq     <= s2_eq_r;
    s3_r.gt     <= s2_gt_r;
    s3_r.value  <= fast_nxt.value;
    s3_r.ovf    <= fast_nxt.ovf;
    s3_mul_r    <= s2_act_r == fpa_pkg::ACT_MUL;
    s3_prod_r   <= s2_ma_r * s2_mb_r;
  end

  // stage 4: round the product, ties away from zero
  logic [2*DW:0]  prod_rnd;
  fpa_pkg::sat_t  mul_sat;
  fpa_pkg::res_t  s4_nxt;

  always_comb begin
    prod_rnd = ({1'b0, s3_prod_r} + ((2*DW+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    mul_sat  = fpa_pkg::sat_mag(s3_r.neg, prod_rnd);
    s4_nxt   = s3_r;
    if (s3_mul_r) begin
      s4_nxt.value = mul_sat.value;
      s4_nxt.ovf   = mul_sat.ovf;
    end
  end

  // delay line matching the divider depth
  logic [DLY-1:0]  dly_vld_r;
  fpa_pkg::res_t   dly_r [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else begin
      dly_vld_r <= {dly_vld_r[DLY-2:0], s3_vld_r};
    end
    dly_r[0] <= s4_nxt;
    for (int i = 1; i < DLY; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem, div_den;

  fpa_div #(
    .NW (NW)
  ) u_div (
    .clk     (clk),
    .in_num  ({s2_ma_r, {FRACTION_BITS{1'b0}}}),
    .in_den  (s2_mb_r),
    .out_quo (div_quo),
    .out_rem (div_rem),
    .out_den (div_den)
  );

  // final stage: quotient rounding and result select
  logic           q_up;
  logic [NW:0]    q_rnd;
  fpa_pkg::sat_t  div_sat;
  fpa_pkg::res_t  tail;
  fpa_pkg::res_t  out_nxt;

  always_comb begin
    tail    = dly_r[DLY-1];
    q_up    = {div_rem, 1'b0} >= {1'b0, div_den};
    q_rnd   = {1'b0, div_quo} + (NW+1)'(q_up);
    div_sat = fpa_pkg::sat_mag(tail.neg, {{(64-NW){1'b0}}, q_rnd});
    out_nxt = tail;
    if (tail.is_div) begin
      out_nxt.value = tail.dbz ? '0 : div_sat.value;
      out_nxt.ovf   = tail.dbz ? 1'b0 : div_sat.ovf;
    end
  end

  logic out_vld_r;
  fpa_pkg::res_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dly_vld_r[DLY-1];
    end
    out_r <= out_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_result_value   = out_r.value;
  assign out_a_less         = out_r.lt;
  assign out_a_equal        = out_r.eq;
  assign out_a_greater      = out_r.gt;
  assign out_divide_by_zero = out_r.dbz;
  assign out_overflow       = out_r.ovf;

`ifndef SYNTHESIS
  a_cmp_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not one-hot");

  a_dbz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow && out_result_value == 0)
    else $error("divide by zero result not cleared");

  a_sat_value : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_result_value == 32'sh7FFF_FFFF || out_result_value == -32'sh8000_0000)
    else $error("overflow without saturated value");
`endif

endmodule

[test/fixed_point_q24_8_alu_unit_test.sv]
`timescale 1ns / 1ps
// self-checking bench for the q24.8 fixed-point alu: directed corner cases,
// then random bursts of transactions checked against an in-bench predictor
// depends on fpa_pkg and fixed_point_q24_8_alu_unit

module fixed_point_q24_8_alu_unit_test;

  localparam int FRAC = 8;
  localparam int LATENCY = 34 + FRAC;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dbz;
    logic        ovf;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          mismatches;
    int          checked;

    function logic [31:0] clamp_wide(input longint v, output logic ovf);
      ovf = 1'b0;
      if (v > 64'sd2147483647) begin
        ovf = 1'b1;
        return fpa_pkg::POS_MAX;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1'b1;
        return fpa_pkg::NEG_MAX;
      end
      return v[31:0];
    endfunction

    function logic [31:0] apply_sign(input bit neg, input logic [63:0] mag,
                                     output logic ovf);
      ovf = 1'b0;
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          ovf = 1'b1;
          return fpa_pkg::NEG_MAX;
        end
        return -mag[31:0];
      end
      if (mag > 64'h7FFF_FFFF) begin
        ovf = 1'b1;
        return fpa_pkg::POS_MAX;
      end
      return mag[31:0];
    endfunction

    function alu_result_t compute(input logic [3:0] act, input logic [31:0] ra,
                                  input logic [31:0] rb);
      alu_result_t r;
      longint a;
      longint b;
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      r.value = '0;
      r.dbz = 1'b0;
      r.ovf = 1'b0;
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      case (act)
        fpa_pkg::ACT_ADD: r.value = clamp_wide(a + b, r.ovf);
        fpa_pkg::ACT_SUB: r.value = clamp_wide(a - b, r.ovf);
        fpa_pkg::ACT_MUL: begin
          q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
          r.value = apply_sign((a < 0) != (b < 0), q, r.ovf);
        end
        fpa_pkg::ACT_DIV: begin
          if (b == 0) begin
            r.dbz = 1'b1;
          end else begin
            q = (2 * (ma << FRAC) + mb) / (2 * mb);
            r.value = apply_sign((a < 0) != (b < 0), q, r.ovf);
          end
        end
        fpa_pkg::ACT_MIN: r.value = (a < b) ? ra : rb;
        fpa_pkg::ACT_MAX: r.value = (a > b) ? ra : rb;
        fpa_pkg::ACT_INC: r.value = clamp_wide(a + 1, r.ovf);
        fpa_pkg::ACT_DEC: r.value = clamp_wide(a - 1, r.ovf);
        fpa_pkg::ACT_INT: r.value = $signed(ra) >>> FRAC;
        default: r.value = '0;
      endcase
      return r;
    endfunction

    function void note_input(input logic [3:0] act, input logic [31:0] ra,
                             input logic [31:0] rb);
      pending.push_back(compute(act, ra, rb));
    endfunction

    function void check_result(input alu_result_t got);
      alu_result_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h", got.value);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp val=%h lt%b eq%b gt%b dbz%b ovf%b",
                   exp_r.value, exp_r.lt, exp_r.eq, exp_r.gt, exp_r.dbz, exp_r.ovf);
          $display("          got val=%h lt%b eq%b gt%b dbz%b ovf%b",
                   got.value, got.lt, got.eq, got.gt, got.dbz, got.ovf);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  in_action;
  logic signed [31:0] in_operand_a;
  logic signed [31:0] in_operand_b;
  logic        out_valid;
  logic signed [31:0] out_result_value;
  logic        out_a_less;
  logic        out_a_equal;
  logic        out_a_greater;
  logic        out_divide_by_zero;
  logic        out_overflow;

  alu_scoreboard sb;
  int          sent;

  fixed_point_q24_8_alu_unit #(.FRACTION_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_a_less(out_a_less), .out_a_equal(out_a_equal),
    .out_a_greater(out_a_greater), .out_divide_by_zero(out_divide_by_zero),
    .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

  // sample both handshakes at the edge
  always @(posedge clk) begin
    alu_result_t got;
    if (rst_n && start && !busy) sb.note_input(in_action, in_operand_a, in_operand_b);
    if (rst_n && out_valid) begin
      got.value = out_result_value;
      got.lt = out_a_less;
      got.eq = out_a_equal;
      got.gt = out_a_greater;
      got.dbz = out_divide_by_zero;
      got.ovf = out_overflow;
      sb.check_result(got);
    end
  end

  // hold the transaction until it is taken; start stays high across bursts
  task automatic issue(input logic [3:0] act, input logic [31:0] ra, input logic [31:0] rb);
    start <= 1'b1;
    in_action <= act;
    in_operand_a <= ra;
    in_operand_b <= rb;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return fpa_pkg::POS_MAX - $urandom_range(0, 3);
      1: return fpa_pkg::NEG_MAX + $urandom_range(0, 3);
      2: return $urandom_range(0, 2) - 1;
      3: return $signed($urandom_range(0, 4096)) - 2048;
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      5: return 32'($urandom_range(0, 255)) << 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corners[8];
    logic [31:0] ra;
    logic [31:0] rb;
    int burst;
    int wait_cycles;
    sb = new();
    sent = 0;
    corners = '{fpa_pkg::POS_MAX, fpa_pkg::NEG_MAX, 32'd0, 32'hFFFF_FFFF, 32'd1,
                32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= fpa_pkg::ACT_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every action, saturation, divide by zero, ties, unused codes
    issue(fpa_pkg::ACT_ADD, fpa_pkg::POS_MAX, 32'd1);
    issue(fpa_pkg::ACT_ADD, fpa_pkg::NEG_MAX, fpa_pkg::NEG_MAX);
    issue(fpa_pkg::ACT_SUB, fpa_pkg::NEG_MAX, 32'd1);
    issue(fpa_pkg::ACT_SUB, fpa_pkg::POS_MAX, fpa_pkg::NEG_MAX);
    issue(fpa_pkg::ACT_MUL, fpa_pkg::POS_MAX, fpa_pkg::POS_MAX);
    issue(fpa_pkg::ACT_MUL, fpa_pkg::NEG_MAX, 32'h0000_0100);
    issue(fpa_pkg::ACT_MUL, 32'h0000_0080, 32'h0000_0001);
    issue(fpa_pkg::ACT_MUL, 32'hFFFF_FF80, 32'h0000_0001);
    issue(fpa_pkg::ACT_DIV, 32'h0000_0100, 32'd0);
    issue(fpa_pkg::ACT_DIV, fpa_pkg::NEG_MAX, 32'hFFFF_FF00);
    issue(fpa_pkg::ACT_DIV, fpa_pkg::POS_MAX, 32'd1);
    issue(fpa_pkg::ACT_DIV, 32'd1, 32'd512);
    issue(fpa_pkg::ACT_DIV, 32'hFFFF_FFFF, 32'd512);
    issue(fpa_pkg::ACT_MIN, fpa_pkg::NEG_MAX, fpa_pkg::POS_MAX);
    issue(fpa_pkg::ACT_MAX, fpa_pkg::NEG_MAX, fpa_pkg::POS_MAX);
    issue(fpa_pkg::ACT_INC, fpa_pkg::POS_MAX, 32'd0);
    issue(fpa_pkg::ACT_DEC, fpa_pkg::NEG_MAX, 32'd0);
    issue(fpa_pkg::ACT_INT, 32'hFFFF_FFFF, 32'd5);
    issue(fpa_pkg::ACT_INT, fpa_pkg::POS_MAX, fpa_pkg::POS_MAX);
    issue(fpa_pkg::ACT_INT, fpa_pkg::NEG_MAX, 32'd0);
    issue(4'd9, 32'd3, 32'd3);
    issue(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle(1);

    // hold off until everything in flight has drained
    while (sb.pending.size() != 0) @(posedge clk);

    while (sent < 520) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0) begin
          ra = corners[$urandom_range(0, 7)];
          rb = corners[$urandom_range(0, 7)];
        end else begin
          ra = pick_operand();
          rb = ($urandom_range(0, 7) == 0) ? ra : pick_operand();
        end
        issue(($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8)), ra, rb);
      end
      wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (wait_cycles != 0) idle(wait_cycles);
    end
    idle(1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d transactions over all actions, unused codes and operand corners",
             sent);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
